// ----- sv/wgb_pkg.sv -----
// ----------------------------------------------------------------------------
// wgb_pkg
// shared types and constants of the waypoint graph builder
// ----------------------------------------------------------------------------
package wgb_pkg;

  localparam int MAX_NODES = 256;
  localparam int ADDR_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int COORD_W   = 20;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * COORD_W + 1;
  localparam int ROOT_W    = (SQ_W + 1) / 2;
  localparam int IDX_W     = 8;
  localparam int LEN_W     = 21;
  localparam int NODE_W    = 3 * COORD_W;
  localparam int RADIUS_W  = 16;
  localparam int R2_W      = 2 * RADIUS_W;
  localparam int SAVE_W    = 19;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(768);
  localparam logic [SAVE_W-1:0]   SAVE_RESET   = SAVE_W'(256000);

  // register index, taken from the word address
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_SAVE   = 1'b1;

  typedef enum logic {
    OP_POSE  = 1'b0,
    OP_CLEAR = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_MATCHED = 3'd0,
    ST_CREATED = 3'd1,
    ST_SAVE    = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_y;
    logic signed [COORD_W-1:0]  coord_z;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [IDX_W-1:0]    node_index;
    logic                edge_valid;
    logic [IDX_W-1:0]    edge_from;
    logic [IDX_W-1:0]    edge_to;
    logic [LEN_W-1:0]    edge_length;
  } result_t;

endpackage

// ----- sv/wgb_ram.sv -----
// ----------------------------------------------------------------------------
// wgb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module wgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/wgb_isqrt.sv -----
// ----------------------------------------------------------------------------
// wgb_isqrt
// bit-pair serial integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module wgb_isqrt
  import wgb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam logic [SQ_W-1:0] BIT_INIT = SQ_W'(1) << (2 * (ROOT_W - 1));

  logic            act_q, act_d;
  logic            done_q, done_d;
  logic [SQ_W-1:0] rem_q, rem_d;
  logic [SQ_W-1:0] root_q, root_d;
  logic [SQ_W-1:0] bit_q, bit_d;
  logic [SQ_W:0]   trial;

  assign trial = {1'b0, root_q} + {1'b0, bit_q};

  always_comb begin
    act_d  = act_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    if (start_i) begin
      act_d  = 1'b1;
      rem_d  = radicand_i;
      root_d = '0;
      bit_d  = BIT_INIT;
    end else if (act_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d  = rem_q - trial[SQ_W-1:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d = bit_q >> 2;
      // last bit pair
      if (bit_q[0]) begin
        act_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      act_q  <= act_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = root_q[ROOT_W-1:0];

endmodule

// ----- sv/waypoint_graph_builder.sv -----
// ----------------------------------------------------------------------------
// waypoint_graph_builder
// builds a graph of waypoints from poses: node match or append, edge lengths
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// -------   ---------  --------------------------  ----------------------
// command   in         start high while busy low   cmd_i    (cmd_t)
// result    out        done_o strobe, one cycle    result_o (result_t)
// config    in/out     apb write, pready always 1  pwdata / prdata
//
// a clear or a save request is answered from the check state through the
// result register. a pose scans the node memory one entry a cycle through a
// three stage read/square/compare pipe; a pose that closes an edge then
// squares the edge and waits for the serial root unit to give its length.
// reset clears the state, counters, parity and the configuration registers;
// the node memory needs no clearing pass since no entry at or above the node
// count is ever read.
// the receiver cannot stall: a result is shown for one cycle only, and the
// next command may be taken in that same cycle.
// ----------------------------------------------------------------------------
module waypoint_graph_builder
  import wgb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // command
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd_i,
  // result
  output logic              done_o,
  output result_t           result_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_PAIR    = 7'b0001000,
    S_EDGE_SQ = 7'b0010000,
    S_ROOT_GO = 7'b0100000,
    S_ROOT    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [RADIUS_W-1:0] radius_q;
  logic [SAVE_W-1:0]   save_q;
  logic [R2_W-1:0]     r2_q;
  logic                cfg_wr;

  // command latch
  cmd_t pose_q;
  logic accept;

  // graph state
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] pend_q, pend_d;
  logic              expect_q, expect_d;
  logic signed [COORD_W-1:0] ps_x_q, ps_x_d, ps_y_q, ps_y_d;

  // scan pipe
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              s1_vld_q, s1_vld_d, s2_vld_q, s2_vld_d;
  logic [ADDR_W-1:0] s1_idx_q, s2_idx_q;
  logic signed [COORD_W-1:0] s2_x_q, s2_y_q;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sq_sum;
  logic              hit;

  // resolved node of the current pose
  logic [ADDR_W-1:0] idx_q, idx_d;
  status_e           nstat_q, nstat_d;
  logic signed [COORD_W-1:0] end_x_q, end_x_d, end_y_q, end_y_d;

  // result register
  logic    done_q, done_d;
  result_t res_q, res_d;

  // node memory
  logic              ram_we, ram_re;
  logic [NODE_W-1:0] ram_wdata, ram_rdata;
  logic signed [COORD_W-1:0] rd_x, rd_y;

  // squaring datapath, shared by the scan and the edge length
  logic signed [COORD_W-1:0]  mul_ax, mul_bx, mul_ay, mul_by;
  logic signed [DIFF_W-1:0]   dx, dy;
  logic signed [2*DIFF_W-1:0] px, py;

  // save limit test
  logic [COORD_W-1:0] abs_x, abs_y;
  logic               save_hit;

  // square root unit
  logic              sqrt_go, sqrt_done;
  logic [ROOT_W-1:0] sqrt_root;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // apb configuration port, word addressed
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_RADIUS: prdata = APB_DW'(radius_q);
      REG_SAVE:   prdata = APB_DW'(save_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      save_q   <= SAVE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_RADIUS) begin
        radius_q <= pwdata[RADIUS_W-1:0];
      end else begin
        save_q <= pwdata[SAVE_W-1:0];
      end
    end
  end

  // squared match radius, settled long before the first compare
  always_ff @(posedge clk_i) begin
    r2_q <= radius_q * radius_q;
  end

  // --------------------------------------------------------------------------
  // node memory: {z, y, x} per node
  // --------------------------------------------------------------------------
  assign ram_wdata = {pose_q.coord_z, pose_q.coord_y, pose_q.coord_x};
  assign rd_x      = ram_rdata[COORD_W-1:0];
  assign rd_y      = ram_rdata[2*COORD_W-1:COORD_W];

  wgb_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (issue_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // difference and square: pose against stored node while scanning,
  // edge start against edge end otherwise
  // --------------------------------------------------------------------------
  always_comb begin
    if (state_q == S_EDGE_SQ) begin
      mul_ax = ps_x_q;
      mul_bx = end_x_q;
      mul_ay = ps_y_q;
      mul_by = end_y_q;
    end else begin
      mul_ax = pose_q.coord_x;
      mul_bx = rd_x;
      mul_ay = pose_q.coord_y;
      mul_by = rd_y;
    end
  end

  assign dx = DIFF_W'(mul_ax) - DIFF_W'(mul_bx);
  assign dy = DIFF_W'(mul_ay) - DIFF_W'(mul_by);
  assign px = dx * dx;
  assign py = dy * dy;

  assign sq_sum = sqx_q + sqy_q;
  assign hit    = s2_vld_q && (sq_sum < SQ_W'(r2_q));

  // absolute coordinates for the save limit
  assign abs_x = pose_q.coord_x[COORD_W-1] ? COORD_W'(~pose_q.coord_x + 1'b1)
                                           : COORD_W'(pose_q.coord_x);
  assign abs_y = pose_q.coord_y[COORD_W-1] ? COORD_W'(~pose_q.coord_y + 1'b1)
                                           : COORD_W'(pose_q.coord_y);
  assign save_hit = (abs_x > COORD_W'(save_q)) || (abs_y > COORD_W'(save_q));

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pend_d   = pend_q;
    expect_d = expect_q;
    ps_x_d   = ps_x_q;
    ps_y_d   = ps_y_q;
    issue_d  = issue_q;
    s1_vld_d = 1'b0;
    s2_vld_d = (state_q == S_SCAN) && s1_vld_q;
    idx_d    = idx_q;
    nstat_d  = nstat_q;
    end_x_d  = end_x_q;
    end_y_d  = end_y_q;
    done_d   = 1'b0;
    res_d    = res_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    sqrt_go  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (pose_q.opcode == OP_CLEAR) begin
          count_d       = '0;
          pend_d        = '0;
          expect_d      = 1'b0;
          done_d        = 1'b1;
          res_d         = '0;
          res_d.status  = ST_CLEARED;
          state_d       = S_IDLE;
        end else if (save_hit) begin
          done_d        = 1'b1;
          res_d         = '0;
          res_d.status  = ST_SAVE;
          state_d       = S_IDLE;
        end else begin
          issue_d = '0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue one read a cycle in index order
        if (issue_q < count_q) begin
          ram_re   = 1'b1;
          s1_vld_d = 1'b1;
          issue_d  = issue_q + 1'b1;
        end
        if (hit) begin
          // first hit in order wins, later reads in flight are dropped
          idx_d   = s2_idx_q;
          nstat_d = ST_MATCHED;
          end_x_d = s2_x_q;
          end_y_d = s2_y_q;
          state_d = S_PAIR;
        end else if ((issue_q == count_q) && !s1_vld_q && !s2_vld_q) begin
          if (count_q == CNT_W'(MAX_NODES)) begin
            // table full: pose dropped, parity kept
            done_d       = 1'b1;
            res_d        = '0;
            res_d.status = ST_FULL;
            state_d      = S_IDLE;
          end else begin
            ram_we  = 1'b1;
            idx_d   = count_q[ADDR_W-1:0];
            count_d = count_q + 1'b1;
            nstat_d = ST_CREATED;
            end_x_d = pose_q.coord_x;
            end_y_d = pose_q.coord_y;
            state_d = S_PAIR;
          end
        end
      end

      S_PAIR: begin
        if (!expect_q) begin
          // this node opens an edge
          pend_d           = idx_q;
          ps_x_d           = end_x_q;
          ps_y_d           = end_y_q;
          expect_d         = 1'b1;
          done_d           = 1'b1;
          res_d            = '0;
          res_d.status     = nstat_q;
          res_d.node_index = IDX_W'(idx_q);
          state_d          = S_IDLE;
        end else begin
          state_d = S_EDGE_SQ;
        end
      end

      S_EDGE_SQ: begin
        state_d = S_ROOT_GO;
      end

      S_ROOT_GO: begin
        sqrt_go = 1'b1;
        state_d = S_ROOT;
      end

      S_ROOT: begin
        if (sqrt_done) begin
          expect_d          = 1'b0;
          done_d            = 1'b1;
          res_d.status      = nstat_q;
          res_d.node_index  = IDX_W'(idx_q);
          res_d.edge_valid  = 1'b1;
          res_d.edge_from   = IDX_W'(pend_q);
          res_d.edge_to     = IDX_W'(idx_q);
          res_d.edge_length = LEN_W'(sqrt_root);
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  wgb_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_go),
    .radicand_i (sq_sum),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pend_q   <= '0;
      expect_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      expect_q <= expect_d;
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
      done_q   <= done_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pose_q <= cmd_i;
    end
    ps_x_q   <= ps_x_d;
    ps_y_q   <= ps_y_d;
    issue_q  <= issue_d;
    s1_idx_q <= issue_q[ADDR_W-1:0];
    s2_idx_q <= s1_idx_q;
    s2_x_q   <= rd_x;
    s2_y_q   <= rd_y;
    sqx_q    <= px[SQ_W-1:0];
    sqy_q    <= py[SQ_W-1:0];
    idx_q    <= idx_d;
    nstat_q  <= nstat_d;
    end_x_q  <= end_x_d;
    end_y_q  <= end_y_d;
    res_q    <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && !done_o))
    else $error("transfer did not make the block busy");

  a_edge_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.edge_valid) |->
      (result_o.status == ST_MATCHED || result_o.status == ST_CREATED))
    else $error("edge reported with a status that places no node");

  a_append_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (count_q < CNT_W'(MAX_NODES)))
    else $error("node appended to a full table");

  a_root_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == S_ROOT))
    else $error("root finished outside the edge step");

endmodule

// ----- verif/tb_waypoint_graph_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_waypoint_graph_builder
// self-checking bench: a local model of the node table predicts each result
// ----------------------------------------------------------------------------
//
// commands go in through the start/busy handshake and every transfer is
// mirrored into a small model of the node table, edge parity and registers.
// the model queues one expected result per command; the done_o strobe is
// checked field by field against the oldest one. registers are written over
// apb only while nothing is outstanding. a short directed part covers the
// radius and save-limit boundaries and the coordinate extremes, then random
// phases revisit stored nodes, fill the table until it overflows and mix in
// clears, out-of-range poses and raw noise.
// ----------------------------------------------------------------------------
module tb_waypoint_graph_builder;
  import wgb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  // longest pose with a full table plus the root unit, with some margin
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned PRINT_CAP   = 100;

  // kinds of random command
  typedef enum int {
    K_CLEAR,
    K_REVISIT,
    K_NOISE,
    K_LIMIT,
    K_SPREAD
  } cmd_kind_e;

  // --------------------------------------------------------------------------
  // node table model and result checker
  // --------------------------------------------------------------------------
  class graph_scoreboard;
    logic signed [COORD_W-1:0] node_x [MAX_NODES];
    logic signed [COORD_W-1:0] node_y [MAX_NODES];
    int unsigned               node_count;
    int unsigned               edge_start;
    bit                        closing_edge;
    logic [RADIUS_W-1:0]       radius;
    logic [SAVE_W-1:0]         save_limit;
    result_t                   expected_q [$];
    int unsigned               mismatches;
    int unsigned               full_drops;

    function new();
      radius       = RADIUS_RESET;
      save_limit   = SAVE_RESET;
      node_count   = 0;
      edge_start   = 0;
      closing_edge = 1'b0;
      mismatches   = 0;
      full_drops   = 0;
    endfunction

    function void write_reg(logic idx, logic [APB_DW-1:0] value);
      if (idx == REG_RADIUS) radius = value[RADIUS_W-1:0];
      else                   save_limit = value[SAVE_W-1:0];
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction

    function longint unsigned dist_sq(logic signed [COORD_W-1:0] ax,
                                      logic signed [COORD_W-1:0] ay,
                                      logic signed [COORD_W-1:0] bx,
                                      logic signed [COORD_W-1:0] by);
      longint dx;
      longint dy;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      return longint'(dx * dx) + longint'(dy * dy);
    endfunction

    // floor of the square root, one result bit at a time from the top
    function logic [LEN_W-1:0] int_root(longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      int              b;
      root = 0;
      for (b = LEN_W; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= n) root = trial;
      end
      return root[LEN_W-1:0];
    endfunction

    function void note_cmd(cmd_t c);
      result_t         r;
      longint          ax;
      longint          ay;
      longint unsigned r2;
      int unsigned     idx;
      bit              hit;
      r   = '0;
      idx = 0;
      hit = 1'b0;
      if (c.opcode == OP_CLEAR) begin
        node_count   = 0;
        edge_start   = 0;
        closing_edge = 1'b0;
        r.status     = ST_CLEARED;
      end else begin
        ax = longint'(c.coord_x);
        ay = longint'(c.coord_y);
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        if (ax > longint'(save_limit) || ay > longint'(save_limit)) begin
          r.status = ST_SAVE;
        end else begin
          r2 = longint'(radius) * longint'(radius);
          // first node in index order inside the radius wins
          for (int unsigned i = 0; i < node_count; i++) begin
            if (dist_sq(c.coord_x, c.coord_y, node_x[i], node_y[i]) < r2) begin
              hit = 1'b1;
              idx = i;
              break;
            end
          end
          if (hit) begin
            r.status = ST_MATCHED;
          end else if (node_count >= MAX_NODES) begin
            r.status = ST_FULL;
            full_drops++;
          end else begin
            idx         = node_count;
            node_x[idx] = c.coord_x;
            node_y[idx] = c.coord_y;
            node_count++;
            r.status    = ST_CREATED;
          end
          // a dropped pose leaves the start/end parity alone
          if (r.status != ST_FULL) begin
            r.node_index = idx[IDX_W-1:0];
            if (!closing_edge) begin
              edge_start   = idx;
              closing_edge = 1'b1;
            end else begin
              r.edge_valid  = 1'b1;
              r.edge_from   = edge_start[IDX_W-1:0];
              r.edge_to     = idx[IDX_W-1:0];
              r.edge_length = int_root(dist_sq(node_x[edge_start], node_y[edge_start],
                                               node_x[idx], node_y[idx]));
              closing_edge  = 1'b0;
            end
          end
        end
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing outstanding, status %0d", got.status));
        return;
      end
      want = expected_q.pop_front();
      check_field("status", got.status, want.status);
      check_field("node_index", got.node_index, want.node_index);
      check_field("edge_valid", got.edge_valid, want.edge_valid);
      check_field("edge_from", got.edge_from, want.edge_from);
      check_field("edge_to", got.edge_to, want.edge_to);
      check_field("edge_length", got.edge_length, want.edge_length);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and block
  // --------------------------------------------------------------------------
  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  cmd_t              cmd_i;
  logic              done_o;
  result_t           result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  graph_scoreboard   sb;
  int unsigned       cycles;

  waypoint_graph_builder i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_waypoint_graph_builder NOT OK");
      $finish;
    end
  end

  // results cannot be held off, so every strobe is checked as it passes
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1 && sb != null) sb.check_result(result_o);
  end

  // --------------------------------------------------------------------------
  // command generation
  // --------------------------------------------------------------------------
  function automatic cmd_t pose_cmd(int x, int y, int z);
    cmd_t c;
    c.opcode  = OP_POSE;
    c.coord_x = COORD_W'(x);
    c.coord_y = COORD_W'(y);
    c.coord_z = COORD_W'(z);
    return c;
  endfunction

  // coordinates of a clear are junk the block must ignore
  function automatic cmd_t clear_cmd();
    cmd_t c;
    c         = pose_cmd($urandom(), $urandom(), $urandom());
    c.opcode  = OP_CLEAR;
    return c;
  endfunction

  function automatic int spread_coord(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic cmd_t random_cmd(int unsigned clear_pct, int unsigned revisit_pct);
    int unsigned roll;
    cmd_kind_e   kind;
    int          lim;
    int          span;
    int          x;
    int          y;
    int unsigned j;
    roll = $urandom_range(0, 99);
    lim  = int'(sb.save_limit);
    if (roll < clear_pct)                         kind = K_CLEAR;
    else if (roll < clear_pct + revisit_pct)      kind = K_REVISIT;
    else if (roll < clear_pct + revisit_pct + 8)  kind = K_NOISE;
    else if (roll < clear_pct + revisit_pct + 14) kind = K_LIMIT;
    else                                          kind = K_SPREAD;
    if (kind == K_REVISIT && sb.node_count == 0) kind = K_SPREAD;
    case (kind)
      K_CLEAR: begin
        return clear_cmd();
      end
      K_REVISIT: begin
        // land on or just beside a stored node: hits and near misses
        j    = $urandom_range(0, sb.node_count - 1);
        span = int'(sb.radius) + 2;
        x    = int'(sb.node_x[j]) + int'($urandom_range(0, 2 * span)) - span;
        y    = int'(sb.node_y[j]) + int'($urandom_range(0, 2 * span)) - span;
      end
      K_NOISE: begin
        x = $urandom();
        y = $urandom();
      end
      K_LIMIT: begin
        // exactly on the save limit or one past it, on either axis
        x = lim + int'($urandom_range(0, 1));
        if ($urandom_range(0, 1)) x = -x;
        y = spread_coord(lim);
        if ($urandom_range(0, 1)) begin
          y = x;
          x = spread_coord(lim);
        end
      end
      default: begin
        x = spread_coord(lim);
        y = spread_coord(lim);
      end
    endcase
    return pose_cmd(x, y, $urandom());
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // start stays high until busy is seen low at an edge: that edge is the transfer
  task automatic issue(input cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_cmd(c);
  endtask

  // random gap in the command stream, mostly short, sometimes past the result
  task automatic hold_off(int unsigned idle_pct);
    int unsigned gap;
    if ($urandom_range(0, 99) >= idle_pct) return;
    gap   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 400) : $urandom_range(1, 3);
    start <= 1'b0;
    cmd_i <= clear_cmd();
    repeat (gap) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // setup then access cycle; pready is waited on all the same
  task automatic reg_write(input logic idx, input logic [APB_DW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic set_regs(input logic [APB_DW-1:0] radius, input logic [APB_DW-1:0] limit);
    drain();
    reg_write(REG_RADIUS, radius);
    reg_write(REG_SAVE, limit);
  endtask

  // full_goal stops the phase early once that many poses were dropped
  task automatic run_phase(int unsigned n_items, int unsigned clear_pct,
                           int unsigned revisit_pct, int unsigned idle_pct,
                           int unsigned full_goal);
    int unsigned drops_at_start;
    drops_at_start = sb.full_drops;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (full_goal != 0 && sb.full_drops - drops_at_start >= full_goal) break;
      hold_off(idle_pct);
      issue(random_cmd(clear_pct, revisit_pct));
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb      = new();
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    cmd_i   <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni  <= 1'b1;
    @(posedge clk_i);

    // reset values: radius 768, save limit 256000
    issue(clear_cmd());                          // clear of an empty table
    issue(pose_cmd(0, 0, 0));                    // node 0, opens an edge
    issue(pose_cmd(100, -100, 524287));          // reuses node 0, edge 0 to 0
    issue(pose_cmd(768, 0, -524288));            // exactly on the radius: new node
    issue(pose_cmd(767, 0, 1));                  // just inside node 0
    issue(pose_cmd(256000, -256000, 0));         // on the save limit, still a pose
    issue(pose_cmd(256001, 0, 0));               // x one past the limit
    issue(pose_cmd(0, -256001, 0));              // y one past the limit
    issue(pose_cmd(-524288, 0, 0));              // most negative x
    issue(pose_cmd(524287, 524287, 0));          // both axes at the top
    issue(pose_cmd(-256000, 256000, 0));         // closes a long diagonal edge
    issue(clear_cmd());
    issue(pose_cmd(5, 5, 7));                    // node 0 written again after clear

    // widest radius and limit, written with junk above the register widths
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(clear_cmd());
    issue(pose_cmd(524287, 524287, 0));
    issue(pose_cmd(-524287, -524287, 0));        // longest edge there is
    issue(pose_cmd(-524288, 0, 0));              // still past the limit
    issue(pose_cmd(0, 0, 0));
    issue(pose_cmd(65534, 0, 0));                // matches node 2 at the far radius

    // zero radius and limit: only the origin passes and it never matches
    set_regs(32'd0, 32'd0);
    issue(pose_cmd(0, 0, 0));
    issue(pose_cmd(1, 0, 0));
    issue(pose_cmd(0, 0, -1));
    issue(clear_cmd());

    // general mix around the default scale
    set_regs($urandom_range(200, 3000), $urandom_range(100000, 400000));
    run_phase(160, 3, 30, 33, 0);

    // fill the table past its end without a break in the command stream
    set_regs(32'd3, 32'd524287);
    issue(clear_cmd());
    run_phase(500, 0, 12, 0, 30);

    // huge radius against a tight limit: mostly matches
    set_regs(32'd65535, $urandom_range(1000, 70000));
    run_phase(130, 5, 25, 33, 0);

    // raw register words, masked by the block
    set_regs($urandom(), $urandom());
    run_phase(130, 4, 30, 33, 0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_waypoint_graph_builder OK");
    end else begin
      $display("tb_waypoint_graph_builder NOT OK");
    end
    $finish;
  end

endmodule

// ----- waypoint_graph_builder.f -----
sv/wgb_pkg.sv
sv/wgb_ram.sv
sv/wgb_isqrt.sv
sv/waypoint_graph_builder.sv
verif/tb_waypoint_graph_builder.sv
